// ----- rtl/qds_pkg.sv -----
// Shared types and constants for the quadrature direction and speed block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package qds_pkg;

	// default width of the stored timestamps
	localparam int TIME_BITS_DEF = 32;

	// width of the time_ms field on the sample stream
	localparam int TIME_IN_W = 32;

	// job queue depth between classifier and divider
	localparam int JOB_DEPTH_DEF = 2;

	// pulses_per_rev register
	localparam int PPR_W = 11;
	localparam logic [PPR_W-1:0] PPR_RESET = 11'd20;

	// speed magnitude and signed output widths
	localparam int MAG_W = 16;
	localparam int SPD_W = 17;
	localparam logic [MAG_W-1:0] RPM_NUMERATOR = 16'd60000;

	// APB map
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_PPR = 2'd0;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	// control bits carried with each job
	typedef struct packed {
		logic right;
		logic fresh;
	} qds_job_t;

	localparam int JOB_CTL_W = $bits(qds_job_t);

endpackage

`default_nettype wire

// ----- rtl/quadrature_direction_speed.sv -----
// Top level of the quadrature direction and speed block: stream ports, APB register,
// and the classifier / job queue / divider chain. Depends on qds_pkg, qds_front,
// qds_fifo and qds_back.
`default_nettype none

// Each request on the sample stream carries the two encoder pin levels and a
// millisecond timestamp. A sample in which neither pin moved keeps s_tready high and
// yields nothing. When a pin moved (A wins if both did; a pending B change is
// picked up by a later sample) its level and time are stored, the other pin's time
// is cleared if it lies later (timer wrap), and one result follows: direction,
// signed speed in rpm (negative for a left turn) and a tuser flag that is set when
// the speed was recomputed from two nonzero stamps, i.e. 60000 / ppr / |dt|,
// truncated. Otherwise the last magnitude is repeated. A changing sample holds
// s_tready low until its job is pushed into the queue; the divider runs two 16-step
// bit-serial passes through one shared restoring unit, so a recomputed result goes
// through the classifier, the job queue, both passes and the done state into the
// output register, while a held one skips the passes. Sustained rate is set by that
// divider, which takes no new job until its last result is loaded. A two-entry job
// queue and the output register let samples flow while results wait. pulses_per_rev
// lives at APB address 0 (reset 20, 0 acts as 1); write it only while idle.
module quadrature_direction_speed #(
	parameter int TIME_BITS = qds_pkg::TIME_BITS_DEF,
	parameter int JOB_DEPTH = qds_pkg::JOB_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// sample stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [0] pin_a_level, [1] pin_b_level, [33:2] time_ms, [39:34] zero
	input  wire logic [qds_pkg::S_TDATA_W-1:0]  s_tdata,
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [0] turn_right, [17:1] speed_rpm, [23:18] zero
	output logic [qds_pkg::M_TDATA_W-1:0]       m_tdata,
	// [0] speed_fresh
	output logic                                m_tuser,
	// APB register port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [qds_pkg::APB_AW-1:0]     paddr,
	input  wire logic [qds_pkg::APB_DW-1:0]     pwdata,
	output logic [qds_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	localparam int JOB_W = qds_pkg::JOB_CTL_W + TIME_BITS;

	logic [qds_pkg::PPR_W-1:0] ppr_q;

	// classifier to queue
	logic                    push, full;
	qds_pkg::qds_job_t       push_ctl;
	logic [TIME_BITS-1:0]    push_diff;

	// queue to divider
	logic                    pop, empty;
	logic [JOB_W-1:0]        job_word;
	qds_pkg::qds_job_t       job_ctl;
	logic [TIME_BITS-1:0]    job_diff;

	// result fields
	logic                    res_right, res_fresh;
	logic [qds_pkg::SPD_W-1:0] res_speed;

	// APB: zero-wait, write on the access phase, decode the single register
	assign pready = 1'b1;
	assign prdata = (paddr == qds_pkg::ADDR_PPR) ?
		qds_pkg::APB_DW'(ppr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= qds_pkg::PPR_RESET;
		end else if (psel && penable && pwrite && pready &&
				(paddr == qds_pkg::ADDR_PPR)) begin
			ppr_q <= pwdata[qds_pkg::PPR_W-1:0];
		end
	end

	// classify samples and hold pin state
	qds_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.pin_a_level(s_tdata[0]),
		.pin_b_level(s_tdata[1]),
		.time_ms    (s_tdata[qds_pkg::TIME_IN_W+1:2]),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_diff  (push_diff),
		.full       (full)
	);

	// decouple classifier from divider
	qds_fifo #(
		.W    (JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_jobs (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_ctl, push_diff}),
		.full  (full),
		.pop   (pop),
		.empty (empty),
		.rdata (job_word)
	);

	assign job_ctl  = job_word[JOB_W-1:TIME_BITS];
	assign job_diff = job_word[TIME_BITS-1:0];

	// compute speed and drive the result register
	qds_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(empty),
		.job_pop  (pop),
		.job_ctl  (job_ctl),
		.job_diff (job_diff),
		.ppr      (ppr_q),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_right(res_right),
		.res_speed(res_speed),
		.res_fresh(res_fresh)
	);

	assign m_tdata = {{(qds_pkg::M_TDATA_W - qds_pkg::SPD_W - 1){1'b0}}, res_speed, res_right};
	assign m_tuser = res_fresh;

endmodule

`default_nettype wire

// ----- rtl/qds_front.sv -----
// Sample classifier: detects pin changes, keeps levels and stamps, queues jobs.
// Depends on qds_pkg.
`default_nettype none

module qds_front #(
	parameter int TIME_BITS = qds_pkg::TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic                  pin_a_level,
	input  wire logic                  pin_b_level,
	input  wire logic [qds_pkg::TIME_IN_W-1:0] time_ms,
	output logic                       push,
	output qds_pkg::qds_job_t          push_ctl,
	output logic [TIME_BITS-1:0]       push_diff,
	input  wire logic                  full
);

	logic                   lvl_a_q, lvl_b_q, pend_q;
	logic [TIME_BITS-1:0]   stamp_a_q, stamp_b_q;
	logic [TIME_BITS+qds_pkg::TIME_IN_W-1:0] t_ext;
	logic [TIME_BITS-1:0]   t;
	logic                   accept, a_chg, b_chg;
	logic                   a_gt_b, a_lt_b;

	assign t_ext  = {{TIME_BITS{1'b0}}, time_ms};
	assign t      = t_ext[TIME_BITS-1:0];
	assign s_tready = !pend_q;
	assign accept = s_tvalid && s_tready;
	assign a_chg  = pin_a_level != lvl_a_q;
	assign b_chg  = !a_chg && (pin_b_level != lvl_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_a_q   <= 1'b0;
			lvl_b_q   <= 1'b0;
			stamp_a_q <= '0;
			stamp_b_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (accept && a_chg) begin
				lvl_a_q   <= pin_a_level;
				stamp_a_q <= t;
				if (stamp_b_q > t) begin
					stamp_b_q <= '0;
				end
			end else if (accept && b_chg) begin
				lvl_b_q   <= pin_b_level;
				stamp_b_q <= t;
				if (stamp_a_q > t) begin
					stamp_a_q <= '0;
				end
			end
			if (accept && (a_chg || b_chg)) begin
				pend_q <= 1'b1;
			end else if (push) begin
				pend_q <= 1'b0;
			end
		end
	end

	// evaluate the updated state in the cycle after the change
	assign a_gt_b = stamp_a_q > stamp_b_q;
	assign a_lt_b = stamp_a_q < stamp_b_q;

	always_comb begin
		push           = pend_q && !full;
		push_ctl.right = (lvl_a_q && !lvl_b_q) ? a_gt_b : a_lt_b;
		push_ctl.fresh = (stamp_a_q != '0) && (stamp_b_q != '0);
		push_diff      = a_gt_b ? (stamp_a_q - stamp_b_q) : (stamp_b_q - stamp_a_q);
	end

endmodule

`default_nettype wire

// ----- rtl/qds_fifo.sv -----
// Small job queue between classifier and divider; register storage.
// Depends on qds_pkg only for its default depth.
`default_nettype none

module qds_fifo #(
	parameter int W     = 34,
	parameter int DEPTH = qds_pkg::JOB_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/qds_back.sv -----
// Speed unit: shared bit-serial divider, held magnitude, output register.
// Depends on qds_pkg.
`default_nettype none

module qds_back #(
	parameter int TIME_BITS = qds_pkg::TIME_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       job_empty,
	output logic                            job_pop,
	input  wire qds_pkg::qds_job_t          job_ctl,
	input  wire logic [TIME_BITS-1:0]       job_diff,
	input  wire logic [qds_pkg::PPR_W-1:0]  ppr,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic                            res_right,
	output logic [qds_pkg::SPD_W-1:0]       res_speed,
	output logic                            res_fresh
);

	localparam int QB = qds_pkg::MAG_W;
	localparam int CNTW = $clog2(QB);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV1 = 2'd1;
	localparam logic [1:0] ST_DIV2 = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             st_q;
	logic [CNTW-1:0]        cnt_q;
	logic [TIME_BITS-1:0]   rem_q;
	logic [TIME_BITS-1:0]   dvs_q, diff_q;
	logic [QB-1:0]          dq_q, mag_q;
	logic                   right_q, fresh_q;

	logic [TIME_BITS:0]     shifted, rem_nxt;
	logic                   q_bit;
	logic [QB-1:0]          dq_nxt;
	logic                   last_step, out_free;
	logic [qds_pkg::SPD_W-1:0] mag_ext;

	// one restoring step per cycle; the remainder always stays below the divisor
	always_comb begin
		shifted = {rem_q, dq_q[QB-1]};
		q_bit   = shifted >= {1'b0, dvs_q};
		rem_nxt = q_bit ? (shifted - {1'b0, dvs_q}) : shifted;
		dq_nxt  = {dq_q[QB-2:0], q_bit};
	end

	assign last_step = cnt_q == CNTW'(QB - 1);
	assign out_free  = !res_valid || res_ready;
	assign job_pop   = (st_q == ST_IDLE) && !job_empty;
	assign mag_ext   = {1'b0, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			mag_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if ((st_q == ST_DONE) && out_free) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!job_empty) begin
						st_q <= job_ctl.fresh ? ST_DIV1 : ST_DONE;
					end
				end
				ST_DIV1: begin
					if (last_step) begin
						st_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (last_step) begin
						mag_q <= dq_nxt;
						st_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				right_q <= job_ctl.right;
				fresh_q <= job_ctl.fresh;
				diff_q  <= (job_diff == '0) ? TIME_BITS'(1) : job_diff;
				rem_q   <= '0;
				dq_q    <= qds_pkg::RPM_NUMERATOR;
				dvs_q   <= (ppr == '0) ? TIME_BITS'(1) : TIME_BITS'(ppr);
				cnt_q   <= '0;
			end
			ST_DIV1: begin
				dq_q  <= dq_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					// quotient becomes the dividend of the second pass
					rem_q <= '0;
					dvs_q <= diff_q;
				end else begin
					rem_q <= rem_nxt[TIME_BITS-1:0];
				end
			end
			ST_DIV2: begin
				dq_q  <= dq_nxt;
				rem_q <= rem_nxt[TIME_BITS-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					res_right <= right_q;
					res_fresh <= fresh_q;
					res_speed <= right_q ? mag_ext : (qds_pkg::SPD_W'(0) - mag_ext);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for quadrature_direction_speed: sample requests in, direction and
// signed rpm results out, pulses_per_rev set over APB between phases.
// Depends on rtl/qds_pkg.sv and rtl/quadrature_direction_speed.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// one result: turn_right, speed_rpm (17-bit two's complement), speed_fresh
	typedef struct packed {
		logic        right;
		logic [16:0] speed;
		logic        fresh;
	} rpm_result_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic                          a;
		logic                          b;
		logic [qds_pkg::TIME_IN_W-1:0] t;
		logic                          typed;
		rpm_result_t                   want;
	} probe_row_t;

	localparam int NUM_PROBES = 17;
	localparam int PHASE_ITEMS = 172;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 50;
	localparam int REPORT_LIMIT = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [qds_pkg::S_TDATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [qds_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                           m_tuser;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [qds_pkg::APB_AW-1:0]     paddr;
	logic [qds_pkg::APB_DW-1:0]     pwdata;
	logic [qds_pkg::APB_DW-1:0]     prdata;
	logic                           pready;

	// mirror of the block: stored levels, change stamps, last magnitude, register
	logic                           lvl_a;
	logic                           lvl_b;
	logic [qds_pkg::TIME_IN_W-1:0]  stamp_a;
	logic [qds_pkg::TIME_IN_W-1:0]  stamp_b;
	logic [qds_pkg::MAG_W-1:0]      speed_mag;
	logic [qds_pkg::PPR_W-1:0]      ppr_reg;

	// results still owed by the block, oldest first
	rpm_result_t           pending_rpm [$];
	int                    fail_count = 0;
	// while set, neither side idles
	bit                    calm = 1'b0;

	// encoder walk used by the random part
	logic                           walk_a;
	logic                           walk_b;
	logic [qds_pkg::TIME_IN_W-1:0]  walk_t;
	bit                             walk_fwd;

	// directed rows, run at the reset resolution of 20 pulses per revolution
	probe_row_t probe_tbl [NUM_PROBES] = '{
		// nothing moved after reset: no result
		'{1'b0, 1'b0, 32'd100, 1'b0, '0},
		// first A edge after reset: B stamp still zero, magnitude held at zero
		'{1'b1, 1'b0, 32'd100, 1'b1, '{1'b1, 17'd0, 1'b0}},
		'{1'b1, 1'b1, 32'd150, 1'b0, '0},
		// equal stamps: difference taken as one, left turn
		'{1'b0, 1'b1, 32'd150, 1'b1, '{1'b0, -17'sd3000, 1'b1}},
		// top of the timer: huge difference, speed truncates to zero
		'{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 17'd0, 1'b1}},
		// timer wrap: A lands before B, B stamp cleared, magnitude held
		'{1'b1, 1'b0, 32'd5, 1'b1, '{1'b1, 17'd0, 1'b0}},
		// both pins move: A first, B left pending
		'{1'b0, 1'b1, 32'd10, 1'b0, '0},
		'{1'b0, 1'b1, 32'd12, 1'b0, '0},
		'{1'b1, 1'b1, 32'd12, 1'b0, '0},
		// timestamp zero on A clears B, held magnitude shown negative
		'{1'b0, 1'b1, 32'd0, 1'b0, '0},
		// same held magnitude, now positive
		'{1'b0, 1'b0, 32'd1, 1'b0, '0},
		'{1'b1, 1'b0, 32'd2, 1'b0, '0},
		'{1'b1, 1'b0, 32'd2, 1'b0, '0},
		'{1'b1, 1'b1, 32'h8000_0000, 1'b0, '0},
		// both move again, B picked up by the repeat
		'{1'b0, 1'b0, 32'h7FFF_FFF0, 1'b0, '0},
		'{1'b0, 1'b0, 32'h7FFF_FFF0, 1'b0, '0},
		'{1'b0, 1'b0, 32'h7FFF_FFF0, 1'b0, '0}
	};

	quadrature_direction_speed dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Count every failure, show only the first few.
	task automatic flag_failure(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	// Advance the mirror by one accepted sample; return 1 when it owes a result.
	function automatic bit track_encoder_step(input logic a, input logic b,
			input logic [qds_pkg::TIME_IN_W-1:0] t, output rpm_result_t res);
		logic [qds_pkg::TIME_IN_W-1:0] gap;
		logic [31:0]                   per_pulse;
		logic [31:0]                   quo;
		res = '0;
		// A wins when both pins moved; the B change waits for a later sample
		if (a != lvl_a) begin
			lvl_a = a;
			stamp_a = t;
			if (stamp_b > stamp_a) begin
				stamp_b = '0;
			end
		end else if (b != lvl_b) begin
			lvl_b = b;
			stamp_b = t;
			if (stamp_a > stamp_b) begin
				stamp_a = '0;
			end
		end else begin
			return 1'b0;
		end
		// levels 1/0 flip the sense of the stamp comparison
		if (lvl_a && !lvl_b) begin
			res.right = stamp_a > stamp_b;
		end else begin
			res.right = stamp_a < stamp_b;
		end
		// recompute only when both stamps are live, else hold the magnitude
		if (stamp_a != '0 && stamp_b != '0) begin
			gap = (stamp_a > stamp_b) ? stamp_a - stamp_b : stamp_b - stamp_a;
			if (gap == '0) begin
				gap = 32'd1;
			end
			per_pulse = 32'(qds_pkg::RPM_NUMERATOR) /
				((ppr_reg == '0) ? 32'd1 : 32'(ppr_reg));
			quo = per_pulse / 32'(gap);
			speed_mag = quo[qds_pkg::MAG_W-1:0];
			res.fresh = 1'b1;
		end
		res.speed = res.right ? {1'b0, speed_mag} : -{1'b0, speed_mag};
		return 1'b1;
	endfunction

	// Offer one sample request, hold it until taken, then log what it owes.
	task automatic send_sample(input logic a, input logic b,
			input logic [qds_pkg::TIME_IN_W-1:0] t,
			input logic typed, input rpm_result_t want, output bit owed);
		rpm_result_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= {{(qds_pkg::S_TDATA_W-qds_pkg::TIME_IN_W-2){1'b0}}, t, b, a};
		do @(posedge clk); while (!s_tready);
		owed = track_encoder_step(a, b, t, predicted);
		if (owed) begin
			pending_rpm.push_back(typed ? want : predicted);
		end
		// drop valid for a random gap now and then
		if (!calm && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 37);
		end
	endtask

	// Next random sample: mostly clean quadrature steps, some noise.
	task automatic send_random(output bit owed);
		int pick;
		pick = $urandom_range(99);
		if (pick < 70 || pick >= 92) begin
			if ($urandom_range(9) == 0) begin
				walk_fwd = !walk_fwd;
			end
			// forward order 00 -> 10 -> 11 -> 01, backward the reverse
			if ((walk_a == walk_b) == walk_fwd) begin
				walk_a = !walk_a;
			end else begin
				walk_b = !walk_b;
			end
			if (pick < 70) begin
				walk_t = walk_t + $urandom_range(0, 40);
			end else if (pick < 96) begin
				walk_t = 32'hFFFF_FFFF - $urandom_range(0, 20);
			end else begin
				walk_t = $urandom_range(0, 3);
			end
		end else if (pick < 78) begin
			// no pin moved
			walk_t = walk_t + $urandom_range(0, 5);
		end else if (pick < 86) begin
			// both pins jump at once
			walk_a = !walk_a;
			walk_b = !walk_b;
			walk_t = walk_t + $urandom_range(0, 40);
		end else begin
			walk_a = 1'($urandom_range(1));
			walk_b = 1'($urandom_range(1));
			walk_t = $urandom();
		end
		send_sample(walk_a, walk_b, walk_t, 1'b0, '0, owed);
	endtask

	// Write a register: setup cycle, then access until pready.
	task automatic reg_write(input logic [qds_pkg::APB_AW-1:0] addr,
			input logic [qds_pkg::APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == qds_pkg::ADDR_PPR) begin
			ppr_reg = val[qds_pkg::PPR_W-1:0];
		end
	endtask

	// Read a register back and compare; sample mid access cycle.
	task automatic reg_read_check(input logic [qds_pkg::APB_AW-1:0] addr,
			input logic [qds_pkg::APB_DW-1:0] want);
		logic [qds_pkg::APB_DW-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			flag_failure($sformatf("register %0d read: expected %0d, got %0d", addr, want, got));
		end
	endtask

	// Wait for every owed result, bounded, then let the block settle.
	task automatic drain_results();
		int waited;
		waited = 0;
		while (pending_rpm.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: stall at random except during the calm stretch.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 37);
	end

	// Check each result taken against the oldest owed one, field by field.
	always @(posedge clk) begin
		rpm_result_t seen;
		rpm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = {m_tdata[0], m_tdata[17:1], m_tuser};
			if (pending_rpm.size() == 0) begin
				flag_failure($sformatf("result with none owed: right %0b speed %0d fresh %0b",
					seen.right, $signed(seen.speed), seen.fresh));
			end else begin
				want = pending_rpm.pop_front();
				if (seen.right !== want.right) begin
					flag_failure($sformatf("turn_right: expected %0b, got %0b",
						want.right, seen.right));
				end
				if (seen.speed !== want.speed) begin
					flag_failure($sformatf("speed_rpm: expected %0d, got %0d",
						$signed(want.speed), $signed(seen.speed)));
				end
				if (seen.fresh !== want.fresh) begin
					flag_failure($sformatf("speed_fresh: expected %0b, got %0b",
						want.fresh, seen.fresh));
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [qds_pkg::PPR_W-1:0] ppr_plan [6];
		bit                        owed;
		rpm_result_t               left_over;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lvl_a = 1'b0;
		lvl_b = 1'b0;
		stamp_a = '0;
		stamp_b = '0;
		speed_mag = '0;
		ppr_reg = qds_pkg::PPR_RESET;
		walk_a = 1'b0;
		walk_b = 1'b0;
		walk_t = 32'd1000;
		walk_fwd = 1'b1;

		// hold reset, then release it on a clock edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register comes up at its reset value
		reg_read_check(qds_pkg::ADDR_PPR, qds_pkg::APB_DW'(qds_pkg::PPR_RESET));

		// directed table at the reset resolution
		foreach (probe_tbl[i]) begin
			send_sample(probe_tbl[i].a, probe_tbl[i].b, probe_tbl[i].t,
				probe_tbl[i].typed, probe_tbl[i].want, owed);
		end
		s_tvalid <= 1'b0;
		drain_results();

		// resolution sweep: one and 1024, zero (acts as one), full field, then random
		ppr_plan[0] = 11'd1;
		ppr_plan[1] = 11'd1024;
		ppr_plan[2] = 11'd0;
		ppr_plan[3] = 11'd2047;
		ppr_plan[4] = qds_pkg::PPR_W'($urandom_range(1, 1024));
		ppr_plan[5] = qds_pkg::PPR_W'($urandom_range(1, 64));

		foreach (ppr_plan[p]) begin
			// block is drained here: safe to retune
			reg_write(qds_pkg::ADDR_PPR, qds_pkg::APB_DW'(ppr_plan[p]));
			reg_read_check(qds_pkg::ADDR_PPR, qds_pkg::APB_DW'(ppr_plan[p]));
			// one long stretch with no idling on either side
			calm = (p == 1);
			repeat (PHASE_ITEMS) begin
				send_random(owed);
			end
			// pause the sender until every owed result is back
			s_tvalid <= 1'b0;
			drain_results();
		end
		calm = 1'b0;

		// anything still owed now never came
		while (pending_rpm.size() != 0) begin
			left_over = pending_rpm.pop_front();
			flag_failure($sformatf("result never arrived: expected right %0b speed %0d fresh %0b",
				left_over.right, $signed(left_over.speed), left_over.fresh));
		end

		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
